// ----- rtl/u8dv_pkg.sv -----
// ----------------------------------------------------------------------------
// u8dv_pkg
// shared types and constants of the utf-8 decoder and validator
// ----------------------------------------------------------------------------
`default_nettype none

package u8dv_pkg;

    localparam int CP_W    = 21;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // byte classes
    localparam logic [2:0] CLS_ASCII = 3'd0;
    localparam logic [2:0] CLS_LEAD2 = 3'd1;
    localparam logic [2:0] CLS_LEAD3 = 3'd2;
    localparam logic [2:0] CLS_LEAD4 = 3'd3;
    localparam logic [2:0] CLS_CONT  = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_CP       = 2'd0;
    localparam logic [1:0] KIND_INVALID  = 2'd1;
    localparam logic [1:0] KIND_END_FAIL = 2'd2;

    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

    // classified byte as it sits in the queue
    typedef struct packed {
        logic [2:0] cls;
        logic [6:0] val;
        logic       last;
    } t_item;

    typedef struct packed {
        logic  push;
        t_item item;
    } t_push;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

`default_nettype wire

// ----- rtl/u8dv_front.sv -----
// ----------------------------------------------------------------------------
// u8dv_front
// input side: takes one word per cycle while the queue is not full, and classifies the byte
// ----------------------------------------------------------------------------
`default_nettype none

module u8dv_front (
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [7:0]    i_s_tdata,
    input  wire logic          i_s_tlast,
    input  wire logic          i_q_full,
    output u8dv_pkg::t_push    o_push
);

    logic [2:0] w_cls;
    logic [6:0] w_val;

    always_comb begin
        if (i_s_tdata[7] == 1'b0) begin
            w_cls = u8dv_pkg::CLS_ASCII;
            w_val = i_s_tdata[6:0];
        end else if ((i_s_tdata & 8'hE0) == 8'hC0) begin
            w_cls = u8dv_pkg::CLS_LEAD2;
            w_val = {2'b00, i_s_tdata[4:0]};
        end else if ((i_s_tdata & 8'hF0) == 8'hE0) begin
            w_cls = u8dv_pkg::CLS_LEAD3;
            w_val = {3'b000, i_s_tdata[3:0]};
        end else if ((i_s_tdata & 8'hF8) == 8'hF0) begin
            w_cls = u8dv_pkg::CLS_LEAD4;
            w_val = {4'b0000, i_s_tdata[2:0]};
        end else if ((i_s_tdata & 8'hC0) == 8'h80) begin
            w_cls = u8dv_pkg::CLS_CONT;
            w_val = {1'b0, i_s_tdata[5:0]};
        end else begin
            w_cls = u8dv_pkg::CLS_BAD;
            w_val = 7'd0;
        end
    end

    assign o_s_tready       = !i_q_full;
    assign o_push.push      = i_s_tvalid && !i_q_full;
    assign o_push.item.cls  = w_cls;
    assign o_push.item.val  = w_val;
    assign o_push.item.last = i_s_tlast;

endmodule

`default_nettype wire

// ----- rtl/u8dv_queue.sv -----
// ----------------------------------------------------------------------------
// u8dv_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module u8dv_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire u8dv_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output logic                  o_full,
    output u8dv_pkg::t_head       o_head
);

    u8dv_pkg::t_item r_mem [u8dv_pkg::QDEPTH];

    logic [u8dv_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [u8dv_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [u8dv_pkg::QCNT_W-1:0] r_count,  n_count;
    logic                        w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_full  = (r_count == u8dv_pkg::QCNT_W'(u8dv_pkg::QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push.push ? 1'b1 : 1'b0);
        n_rd_ptr = r_rd_ptr + (w_pop ? 1'b1 : 1'b0);
        n_count  = r_count;
        if (i_push.push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/u8dv_back.sv -----
// ----------------------------------------------------------------------------
// u8dv_back
// decode state and output register: assembles code points, checks them
// ----------------------------------------------------------------------------
`default_nettype none

module u8dv_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire u8dv_pkg::t_head  i_head,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [23:0]           o_m_tdata,
    output logic [1:0]            o_m_tuser,
    output logic                  o_m_tlast
);

    logic [u8dv_pkg::CP_W-1:0] r_pv,  n_pv;
    logic [1:0]                r_rem, n_rem;
    logic [2:0]                r_len, n_len;
    logic                      r_failed, n_failed;

    logic                      r_out_valid, n_out_valid;
    logic [u8dv_pkg::CP_W-1:0] r_out_cp, n_out_cp;
    logic [1:0]                r_out_kind, n_out_kind;
    logic                      r_out_end, n_out_end;

    logic [u8dv_pkg::CP_W-1:0] w_cat;
    logic [1:0]                w_rem_dec;
    logic                      w_bad_val;
    logic                      w_emit;
    logic                      w_fail;
    logic [u8dv_pkg::CP_W-1:0] w_cp;
    logic [1:0]                w_kind;
    u8dv_pkg::t_item           w_it;

    assign w_it      = i_head.item;
    assign o_pop     = i_head.valid && (!r_out_valid || i_m_tready);
    assign w_cat     = {r_pv[u8dv_pkg::CP_W-7:0], w_it.val[5:0]};
    assign w_rem_dec = r_rem - 2'd1;

    always_comb begin
        w_bad_val = 1'b0;
        if (r_len == 3'd2 && w_cat < u8dv_pkg::MIN_LEN2) w_bad_val = 1'b1;
        if (r_len == 3'd3 && w_cat < u8dv_pkg::MIN_LEN3) w_bad_val = 1'b1;
        if (r_len == 3'd4 && w_cat < u8dv_pkg::MIN_LEN4) w_bad_val = 1'b1;
        if (w_cat > u8dv_pkg::CP_MAX) w_bad_val = 1'b1;
        if (w_cat >= u8dv_pkg::SURR_LO && w_cat <= u8dv_pkg::SURR_HI) w_bad_val = 1'b1;
    end

    always_comb begin
        n_pv     = r_pv;
        n_rem    = r_rem;
        n_len    = r_len;
        n_failed = r_failed;
        w_emit   = 1'b0;
        w_fail   = 1'b0;
        w_cp     = '0;
        w_kind   = u8dv_pkg::KIND_CP;

        if (o_pop) begin
            if (r_failed) begin
                if (w_it.last) begin
                    w_emit   = 1'b1;
                    w_kind   = u8dv_pkg::KIND_END_FAIL;
                    n_pv     = '0;
                    n_rem    = '0;
                    n_len    = '0;
                    n_failed = 1'b0;
                end
            end else if (r_rem == 2'd0) begin
                case (w_it.cls)
                    u8dv_pkg::CLS_ASCII: begin
                        w_emit = 1'b1;
                        w_cp   = {14'd0, w_it.val};
                        n_pv   = '0;
                        n_len  = '0;
                    end
                    u8dv_pkg::CLS_LEAD2, u8dv_pkg::CLS_LEAD3,
                    u8dv_pkg::CLS_LEAD4: begin
                        if (w_it.last) begin
                            w_fail = 1'b1;
                        end else begin
                            n_pv  = {14'd0, w_it.val};
                            n_len = {1'b0, w_it.cls[1:0]} + 3'd1;
                            n_rem = w_it.cls[1:0];
                        end
                    end
                    default: begin
                        w_fail = 1'b1;
                    end
                endcase
            end else if (w_it.cls != u8dv_pkg::CLS_CONT) begin
                w_fail = 1'b1;
            end else if (w_rem_dec != 2'd0) begin
                if (w_it.last) begin
                    w_fail = 1'b1;
                end else begin
                    n_pv  = w_cat;
                    n_rem = w_rem_dec;
                end
            end else if (w_bad_val) begin
                w_fail = 1'b1;
            end else begin
                w_emit = 1'b1;
                w_cp   = w_cat;
                n_pv   = '0;
                n_rem  = '0;
                n_len  = '0;
            end

            if (w_fail) begin
                w_emit   = 1'b1;
                w_cp     = '0;
                w_kind   = u8dv_pkg::KIND_INVALID;
                n_pv     = '0;
                n_rem    = '0;
                n_len    = '0;
                n_failed = !w_it.last;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_cp    = r_out_cp;
        n_out_kind  = r_out_kind;
        n_out_end   = r_out_end;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_cp    = w_cp;
            n_out_kind  = w_kind;
            n_out_end   = w_it.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= '0;
            r_rem       <= '0;
            r_len       <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv        <= n_pv;
            r_rem       <= n_rem;
            r_len       <= n_len;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cp   <= n_out_cp;
        r_out_kind <= n_out_kind;
        r_out_end  <= n_out_end;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_cp};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_end;

endmodule

`default_nettype wire

// ----- rtl/utf8_decode_validate.sv -----
// ----------------------------------------------------------------------------
// utf8_decode_validate
// streaming utf-8 decoder and validator
//
// input stream: one text byte per word on i_s_tdata, i_s_tlast on the final
// byte of a text. output stream: one word per decoded code point, per first
// failure of a text, and per final byte of a text that failed on an earlier
// byte; o_m_tdata carries the code point, o_m_tuser the kind (0 code point,
// 1 invalid, 2 end after failure), o_m_tlast marks the word that answers the
// final byte. throughput is one byte per cycle while the receiver takes the
// output. an accepted byte is written to the four-entry queue; the decoder
// pops it once the output register is empty or being read out.
// when the receiver stalls the output word holds and the queue fills;
// o_s_tready drops once four bytes wait. reset clears the queue, the
// decode state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_validate (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]       o_m_tuser,   // [1:0] kind
    output logic             o_m_tlast
);

    u8dv_pkg::t_push w_push;
    u8dv_pkg::t_head w_head;
    logic            w_full;
    logic            w_pop;

    u8dv_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    u8dv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    u8dv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/u8dv_checker.sv -----
// ----------------------------------------------------------------------------
// u8dv_checker
// port-level checks on the output stream of the decoder
// ----------------------------------------------------------------------------
`default_nettype none

module u8dv_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] o_m_tdata,
    input  wire logic [1:0]  o_m_tuser,
    input  wire logic        o_m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("output word changed while stalled");

    // failure words carry no code point
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != u8dv_pkg::KIND_CP) |-> (o_m_tdata == 24'd0))
        else $error("failure word with nonzero data");

    // end after failure only on the final byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == u8dv_pkg::KIND_END_FAIL) |-> o_m_tlast)
        else $error("end-after-failure word without tlast");

    // decoded values are scalar values
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == u8dv_pkg::KIND_CP) |->
            (o_m_tdata <= 24'h10FFFF && (o_m_tdata < 24'h00D800 || o_m_tdata > 24'h00DFFF)))
        else $error("code point outside scalar range");

endmodule

bind utf8_decode_validate u8dv_checker u_u8dv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
